// File: src/preemptive_priority_focus_arbiter_unit_assert.svh
// Assertion macros for the focus arbiter.
`ifndef PREEMPTIVE_PRIORITY_FOCUS_ARBITER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_FOCUS_ARBITER_UNIT_ASSERT_SVH

// Condition must hold on every clock out of reset.
`define PPFA_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("ppfa check failed");

// Antecedent implies consequent on the following clock.
`define PPFA_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppfa sequence check failed");

`endif

// File: src/ppfa_pkg.sv
package ppfa_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int CLIENT_W   = 4;
  localparam int PRIO_W     = 3;
  localparam int TAG_W      = 16;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

  localparam logic [1:0] KIND_REQUEST     = 2'd0;
  localparam logic [1:0] KIND_RELEASE     = 2'd1;
  localparam logic [1:0] KIND_RELEASE_ALL = 2'd2;

  localparam logic [1:0] NOTE_GRANT  = 2'd0;
  localparam logic [1:0] NOTE_JUDGE  = 2'd1;
  localparam logic [1:0] NOTE_FORCED = 2'd2;
  localparam logic [1:0] NOTE_DONE   = 2'd3;

  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT,
    OP_PURGE,
    OP_INS_SORT,
    OP_INS_HEAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;
    logic     at_end;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DROP,
    S_REINS,
    S_PURGE,
    S_PUT_HEAD,
    S_PUT_SORT,
    S_RELCHK,
    S_EMIT_J,
    S_EMIT_G,
    S_FORCED,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_STEAL,
    MODE_PLAIN,
    MODE_REL
  } mode_t;

endpackage

// File: src/ppfa_cell.sv
module ppfa_cell (
  input  logic                         clk,
  input  ppfa_pkg::cell_ctrl_t         ctrl,
  input  logic [ppfa_pkg::CLIENT_W-1:0] key_client,
  input  logic [ppfa_pkg::PRIO_W-1:0]   key_prio,
  input  ppfa_pkg::entry_t             new_entry,
  input  ppfa_pkg::entry_t             left_entry,
  input  ppfa_pkg::entry_t             right_entry,
  input  logic                         hit_in,
  output logic                         hit_out,
  output ppfa_pkg::entry_t             entry
);

  ppfa_pkg::entry_t entry_next;
  logic             mine;

  always_comb begin
    mine       = 1'b0;
    entry_next = entry;
    hit_out    = hit_in;
    unique case (ctrl.op)
      ppfa_pkg::OP_SHIFT: begin
        entry_next = right_entry;
      end
      ppfa_pkg::OP_PURGE: begin
        mine    = ctrl.valid && (entry.client == key_client);
        hit_out = hit_in | mine;
        if (hit_out) begin
          entry_next = right_entry;
        end
      end
      ppfa_pkg::OP_INS_SORT: begin
        mine    = (ctrl.valid && (entry.prio >= key_prio)) || ctrl.at_end;
        hit_out = hit_in | mine;
        if (hit_in) begin
          entry_next = left_entry;
        end else if (mine) begin
          entry_next = new_entry;
        end
      end
      ppfa_pkg::OP_INS_HEAD: begin
        mine    = 1'b1;
        hit_out = 1'b1;
        entry_next = hit_in ? left_entry : new_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// File: src/preemptive_priority_focus_arbiter_unit.sv
// Preemptive priority focus arbiter.
// Command channel: a transaction is taken on a clock edge with start high and
// busy low; kind, client_id, client_priority, event_tag, steal_allowed and
// unfocus_keep are sampled then. busy stays high until the transaction ends.
// Result channel: each notice is on the note_* ports for one cycle with
// strobe high; the last one of a transaction is a done notice with last high.
// status, holder_valid, holder_client and entry_total show the outcome of the
// whole transaction on every notice. The receiver cannot stall.
// The list lives in a row of cells; each cycle the row holds or does one shift,
// one purge step, one head insert or one sorted insert. A purge removes the
// matching entries one at a time and ends on a step that finds none; a client
// never holds more than one entry. A release all gives one forced notice per
// entry. The next command is taken the cycle after the done notice. Reset
// empties the list; no clearing pass is needed.
`include "preemptive_priority_focus_arbiter_unit_assert.svh"

module preemptive_priority_focus_arbiter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [ppfa_pkg::CLIENT_W-1:0] client_id,
  input  logic [ppfa_pkg::PRIO_W-1:0]   client_priority,
  input  logic [ppfa_pkg::TAG_W-1:0]    event_tag,
  input  logic                          steal_allowed,
  input  logic                          unfocus_keep,
  output logic                          strobe,
  output logic [1:0]                    note_kind,
  output logic [ppfa_pkg::CLIENT_W-1:0] note_client,
  output logic [ppfa_pkg::TAG_W-1:0]    note_tag,
  output logic                          status,
  output logic                          holder_valid,
  output logic [ppfa_pkg::CLIENT_W-1:0] holder_client,
  output logic [ppfa_pkg::CNT_W-1:0]    entry_total,
  output logic                          last
);

  ppfa_pkg::state_t state, state_next;
  ppfa_pkg::mode_t  mode, mode_next;
  logic [ppfa_pkg::CNT_W-1:0] count, count_next;
  logic [ppfa_pkg::CNT_W-1:0] rem, rem_next;
  logic dropped, dropped_next;
  logic jflag, jflag_next;
  logic gflag, gflag_next;
  logic keep, keep_next;
  logic [ppfa_pkg::CLIENT_W-1:0] cid, cid_next;
  ppfa_pkg::entry_t req, req_next;
  ppfa_pkg::entry_t jent, jent_next;
  ppfa_pkg::entry_t gent, gent_next;

  ppfa_pkg::cell_op_t op;
  ppfa_pkg::entry_t   new_entry;
  logic [ppfa_pkg::PRIO_W-1:0] key_prio;
  ppfa_pkg::entry_t   cells [ppfa_pkg::LIST_DEPTH];
  logic [ppfa_pkg::LIST_DEPTH:0] hits;

  assign hits[0] = 1'b0;

  for (genvar i = 0; i < ppfa_pkg::LIST_DEPTH; i++) begin : g_cell
    ppfa_pkg::cell_ctrl_t ctrl;
    assign ctrl.op     = op;
    assign ctrl.valid  = ppfa_pkg::CNT_W'(i) < count;
    assign ctrl.at_end = ppfa_pkg::CNT_W'(i) == count;
    ppfa_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .key_client  (cid),
      .key_prio    (key_prio),
      .new_entry   (new_entry),
      .left_entry  (cells[(i == 0) ? 0 : i - 1]),
      .right_entry (cells[(i == ppfa_pkg::LIST_DEPTH - 1) ? i : i + 1]),
      .hit_in      (hits[i]),
      .hit_out     (hits[i+1]),
      .entry       (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ppfa_pkg::S_IDLE;
      count   <= '0;
      rem     <= '0;
      dropped <= 1'b0;
      jflag   <= 1'b0;
      gflag   <= 1'b0;
      mode    <= ppfa_pkg::MODE_PLAIN;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rem     <= rem_next;
      dropped <= dropped_next;
      jflag   <= jflag_next;
      gflag   <= gflag_next;
      mode    <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    keep <= keep_next;
    cid  <= cid_next;
    req  <= req_next;
    jent <= jent_next;
    gent <= gent_next;
  end

  always_comb begin
    state_next   = state;
    mode_next    = mode;
    count_next   = count;
    rem_next     = rem;
    dropped_next = dropped;
    jflag_next   = jflag;
    gflag_next   = gflag;
    keep_next    = keep;
    cid_next     = cid;
    req_next     = req;
    jent_next    = jent;
    gent_next    = gent;
    op           = ppfa_pkg::OP_HOLD;
    new_entry    = req;
    key_prio     = req.prio;
    strobe       = 1'b0;
    note_kind    = ppfa_pkg::NOTE_DONE;
    note_client  = '0;
    note_tag     = '0;
    last         = 1'b0;
    unique case (state)
      ppfa_pkg::S_IDLE: begin
        if (start) begin
          keep_next    = unfocus_keep;
          cid_next     = client_id;
          req_next     = '{client: client_id, prio: client_priority, tag: event_tag};
          dropped_next = 1'b0;
          jflag_next   = 1'b0;
          gflag_next   = 1'b0;
          jent_next    = cells[0];
          case (kind)
            ppfa_pkg::KIND_REQUEST: begin
              if (count == '0) begin
                mode_next  = ppfa_pkg::MODE_PLAIN;
                state_next = ppfa_pkg::S_PUT_HEAD;
              end else if (steal_allowed) begin
                mode_next  = ppfa_pkg::MODE_STEAL;
                jflag_next = 1'b1;
                state_next = ppfa_pkg::S_DROP;
              end else begin
                mode_next  = ppfa_pkg::MODE_PLAIN;
                state_next = ppfa_pkg::S_PURGE;
              end
            end
            ppfa_pkg::KIND_RELEASE: begin
              mode_next = ppfa_pkg::MODE_REL;
              if (count == '0) begin
                state_next = ppfa_pkg::S_DONE;
              end else if (cells[0].client != client_id) begin
                state_next = ppfa_pkg::S_PURGE;
              end else begin
                jflag_next = 1'b1;
                state_next = ppfa_pkg::S_DROP;
              end
            end
            ppfa_pkg::KIND_RELEASE_ALL: begin
              if (count == '0) begin
                state_next = ppfa_pkg::S_DONE;
              end else begin
                rem_next   = count;
                count_next = '0;
                state_next = ppfa_pkg::S_FORCED;
              end
            end
            default: begin
              state_next = ppfa_pkg::S_DONE;
            end
          endcase
        end
      end
      ppfa_pkg::S_DROP: begin
        op         = ppfa_pkg::OP_SHIFT;
        count_next = count - ppfa_pkg::CNT_W'(1);
        if (keep) begin
          state_next = ppfa_pkg::S_REINS;
        end else if (mode == ppfa_pkg::MODE_REL) begin
          state_next = ppfa_pkg::S_RELCHK;
        end else begin
          state_next = ppfa_pkg::S_PURGE;
        end
      end
      ppfa_pkg::S_REINS: begin
        op         = ppfa_pkg::OP_INS_SORT;
        new_entry  = jent;
        key_prio   = jent.prio;
        count_next = count + ppfa_pkg::CNT_W'(1);
        state_next = (mode == ppfa_pkg::MODE_REL) ? ppfa_pkg::S_RELCHK : ppfa_pkg::S_PURGE;
      end
      ppfa_pkg::S_PURGE: begin
        op = ppfa_pkg::OP_PURGE;
        if (hits[ppfa_pkg::LIST_DEPTH]) begin
          count_next = count - ppfa_pkg::CNT_W'(1);
        end else begin
          unique case (mode)
            ppfa_pkg::MODE_STEAL: state_next = ppfa_pkg::S_PUT_HEAD;
            ppfa_pkg::MODE_PLAIN: state_next = ppfa_pkg::S_PUT_SORT;
            default:              state_next = ppfa_pkg::S_DONE;
          endcase
        end
      end
      ppfa_pkg::S_PUT_HEAD: begin
        if (count == ppfa_pkg::CNT_FULL) begin
          dropped_next = 1'b1;
          state_next   = jflag ? ppfa_pkg::S_EMIT_J : ppfa_pkg::S_DONE;
        end else begin
          op         = ppfa_pkg::OP_INS_HEAD;
          count_next = count + ppfa_pkg::CNT_W'(1);
          gflag_next = 1'b1;
          gent_next  = req;
          state_next = jflag ? ppfa_pkg::S_EMIT_J : ppfa_pkg::S_EMIT_G;
        end
      end
      ppfa_pkg::S_PUT_SORT: begin
        if (count == ppfa_pkg::CNT_FULL) begin
          dropped_next = 1'b1;
        end else begin
          op         = ppfa_pkg::OP_INS_SORT;
          count_next = count + ppfa_pkg::CNT_W'(1);
        end
        state_next = ppfa_pkg::S_DONE;
      end
      ppfa_pkg::S_RELCHK: begin
        if (count != '0 && cells[0].client != cid) begin
          gflag_next = 1'b1;
          gent_next  = cells[0];
        end
        state_next = ppfa_pkg::S_EMIT_J;
      end
      ppfa_pkg::S_EMIT_J: begin
        strobe      = 1'b1;
        note_kind   = ppfa_pkg::NOTE_JUDGE;
        note_client = jent.client;
        note_tag    = jent.tag;
        state_next  = gflag ? ppfa_pkg::S_EMIT_G : ppfa_pkg::S_DONE;
      end
      ppfa_pkg::S_EMIT_G: begin
        strobe      = 1'b1;
        note_kind   = ppfa_pkg::NOTE_GRANT;
        note_client = gent.client;
        note_tag    = gent.tag;
        state_next  = ppfa_pkg::S_DONE;
      end
      ppfa_pkg::S_FORCED: begin
        strobe      = 1'b1;
        note_kind   = ppfa_pkg::NOTE_FORCED;
        note_client = cells[0].client;
        note_tag    = cells[0].tag;
        op          = ppfa_pkg::OP_SHIFT;
        rem_next    = rem - ppfa_pkg::CNT_W'(1);
        if (rem == ppfa_pkg::CNT_W'(1)) begin
          state_next = ppfa_pkg::S_DONE;
        end
      end
      ppfa_pkg::S_DONE: begin
        strobe     = 1'b1;
        note_kind  = ppfa_pkg::NOTE_DONE;
        last       = 1'b1;
        state_next = ppfa_pkg::S_IDLE;
      end
      default: begin
        state_next = ppfa_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state != ppfa_pkg::S_IDLE);
  assign status        = dropped;
  assign holder_valid  = (count != '0);
  assign holder_client = (count != '0) ? cells[0].client : '0;
  assign entry_total   = count;

  `PPFA_ALWAYS(a_count_range, clk, rst, count <= ppfa_pkg::CNT_FULL)
  `PPFA_NEXT(a_done_frees, clk, rst, strobe && last, !busy)
  `PPFA_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `PPFA_ALWAYS(a_last_is_done, clk, rst, !last || (strobe && note_kind == ppfa_pkg::NOTE_DONE))

endmodule
